FILE: design/rigid_bond_constraint_correction_unit_assert.svh
// Assertion macros used by the top design file.
// Each expects clk and rst_n in the scope of use.
`ifndef RIGID_BOND_CONSTRAINT_CORRECTION_UNIT_ASSERT_SVH
`define RIGID_BOND_CONSTRAINT_CORRECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define RBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbc: same-cycle check failed");

// next-cycle implication
`define RBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbc: next-cycle check failed");

`endif

FILE: design/rbc_pkg.sv
package rbc_pkg;

  // quotient bits produced by one divider pipe (quotient saturates at 2^63-1)
  localparam int QBITS = 63;
  localparam logic [63:0] SAT_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

  // per-item data that rides along the divider pipes
  typedef struct packed {
    logic             kind;
    logic             pres;
    logic             fail;
    logic             gneg;
    logic [2:0][31:0] vmag;
    logic [2:0]       vneg;
    logic [31:0]      m1;
    logic [31:0]      m2;
    logic [32:0]      msum;
  } rbc_side_t;

endpackage

FILE: design/rigid_bond_constraint_correction_unit.sv
// Rigid bond constraint correction: one SHAKE (kind 0) or RATTLE (kind 1)
// step per input word, one result word per input word, in input order.
// Input channel in_valid/in_ready carries separation, aux vector, masses.
// Result channel out_valid/out_ready carries status, repeat flag and six
// Q32.32 corrections. Config regs sit on an APB-style port at 8*index.
// Throughput: one word per cycle while in_ready is high; the 138-stage
// pipeline (fold, products, sums, two 64-stage one-bit-per-stage dividers,
// split multipliers) takes a new word each cycle unless a stall freezes it.
// Output has a head register plus one skid register; when the receiver
// stalls the skid fills and the whole pipeline freezes (in_ready low) until
// the head word is taken. Nothing is dropped or repeated across stalls.
// Reset (synchronous, active low) clears all valid bits and the output
// buffer and loads the register defaults; no clearing pass is needed.
// Config is to be written by the user only while no word is in flight; the block does not enforce it.
`include "rigid_bond_constraint_correction_unit_assert.svh"
module rigid_bond_constraint_correction_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic        in_partner_present,
  input  logic [31:0] in_sep_x,
  input  logic [31:0] in_sep_y,
  input  logic [31:0] in_sep_z,
  input  logic [31:0] in_aux_x,
  input  logic [31:0] in_aux_y,
  input  logic [31:0] in_aux_z,
  input  logic [31:0] in_mass_first,
  input  logic [31:0] in_mass_second,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic        out_needs_repeat,
  output logic [63:0] out_corr_first_x,
  output logic [63:0] out_corr_first_y,
  output logic [63:0] out_corr_first_z,
  output logic [63:0] out_corr_second_x,
  output logic [63:0] out_corr_second_y,
  output logic [63:0] out_corr_second_z,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rbc_pkg::*;

  // register indexes
  localparam logic [2:0] REG_BOX_X   = 3'd0;
  localparam logic [2:0] REG_BOX_Y   = 3'd1;
  localparam logic [2:0] REG_BOX_Z   = 3'd2;
  localparam logic [2:0] REG_LEN_SQ  = 3'd3;
  localparam logic [2:0] REG_POS_TOL = 3'd4;
  localparam logic [2:0] REG_VEL_TOL = 3'd5;

  typedef struct packed {
    logic             status;
    logic             needs_repeat;
    logic [5:0][63:0] corr;   // first x,y,z then second x,y,z
  } rbc_word_t;

  // minimum-image fold: at most one box shift, ties stay put
  function automatic logic [31:0] fold_axis(input logic [31:0] d, input logic [30:0] len);
    logic signed [33:0] dd;
    logic signed [33:0] ll;
    logic signed [33:0] res;
    dd = {{2{d[31]}}, d};
    ll = {3'b000, len};
    if ((dd <<< 1) > ll)       res = dd - ll;
    else if ((dd <<< 1) < -ll) res = dd + ll;
    else                       res = dd;
    return res[31:0];
  endfunction

  // ---------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------
  logic [30:0] box_x_r, box_y_r, box_z_r;
  logic [47:0] len_sq_r;
  logic [31:0] pos_tol_r;
  logic [47:0] vel_tol_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r   <= 31'd655360;
      box_y_r   <= 31'd655360;
      box_z_r   <= 31'd655360;
      len_sq_r  <= 48'd65536;
      pos_tol_r <= 32'd4295;
      vel_tol_r <= 48'd66;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BOX_X:   box_x_r   <= pwdata[30:0];
        REG_BOX_Y:   box_y_r   <= pwdata[30:0];
        REG_BOX_Z:   box_z_r   <= pwdata[30:0];
        REG_LEN_SQ:  len_sq_r  <= pwdata[47:0];
        REG_POS_TOL: pos_tol_r <= pwdata[31:0];
        REG_VEL_TOL: vel_tol_r <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_X:   prdata = {33'd0, box_x_r};
      REG_BOX_Y:   prdata = {33'd0, box_y_r};
      REG_BOX_Z:   prdata = {33'd0, box_z_r};
      REG_LEN_SQ:  prdata = {16'd0, len_sq_r};
      REG_POS_TOL: prdata = {32'd0, pos_tol_r};
      REG_VEL_TOL: prdata = {16'd0, vel_tol_r};
      default:     prdata = 64'd0;
    endcase
  end

  // tol * length_sq, built in two steps; follows config, which the user must change only while idle (not enforced)
  logic [55:0] tlp_hi_r, tlp_lo_r;
  logic [79:0] tol_ls_r;

  always_ff @(posedge clk) begin
    tlp_hi_r <= pos_tol_r * len_sq_r[47:24];
    tlp_lo_r <= pos_tol_r * len_sq_r[23:0];
    tol_ls_r <= {tlp_hi_r, 24'd0} + {24'd0, tlp_lo_r};
  end

  // ---------------------------------------------------------------
  // Global advance: frozen only while the skid register is full
  // ---------------------------------------------------------------
  logic en;
  logic head_vld_r, skid_vld_r;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  // ---------------------------------------------------------------
  // P0: input capture
  // ---------------------------------------------------------------
  logic             v0_r, kind0_r, pres0_r;
  logic [2:0][31:0] sep0_r, aux0_r;
  logic [31:0]      m1_0_r, m2_0_r;

  // P1: folded separations
  logic             v1_r, kind1_r, pres1_r;
  logic [2:0][31:0] r1_r, t1_r;
  logic [31:0]      m1_1_r, m2_1_r;
  logic [2:0][31:0] r1_nxt, t1_nxt;
  logic [2:0][30:0] lens;

  assign lens = {box_z_r, box_y_r, box_x_r};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r1_nxt[j] = fold_axis(sep0_r[j], lens[j]);
      t1_nxt[j] = kind0_r ? aux0_r[j] : fold_axis(aux0_r[j], lens[j]);
    end
  end

  // P2: products, correction vector, mass sum
  logic             v2_r, kind2_r, pres2_r;
  logic [2:0][63:0] sq2_r, tr2_r;
  logic [2:0][31:0] vec2_r;
  logic [31:0]      m1_2_r, m2_2_r;
  logic [32:0]      msum2_r;
  logic [2:0][63:0] sq2_nxt, tr2_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq2_nxt[j] = $signed(r1_r[j]) * $signed(r1_r[j]);
      tr2_nxt[j] = $signed(t1_r[j]) * $signed(r1_r[j]);
    end
  end

  // P3: r^2 and dot sums; vector magnitudes
  logic               v3_r;
  rbc_side_t          side3_r, side3_nxt;
  logic [63:0]        r2_3_r;
  logic signed [65:0] dot3_r;

  always_comb begin
    side3_nxt      = '0;
    side3_nxt.kind = kind2_r;
    side3_nxt.pres = pres2_r;
    side3_nxt.m1   = m1_2_r;
    side3_nxt.m2   = m2_2_r;
    side3_nxt.msum = msum2_r;
    for (int j = 0; j < 3; j++) begin
      side3_nxt.vneg[j] = vec2_r[j][31];
      side3_nxt.vmag[j] = vec2_r[j][31] ? (32'd0 - vec2_r[j]) : vec2_r[j];
    end
  end

  // P4: r2 - D2, |dot|
  logic        v4_r;
  rbc_side_t   side4_r;
  logic [64:0] dsub4_r;
  logic [63:0] dmag4_r;
  logic        dneg4_r;
  logic [65:0] dabs;

  assign dabs = dot3_r[65] ? (66'd0 - dot3_r) : dot3_r;

  // P5: |r2 - D2|
  logic        v5_r;
  rbc_side_t   side5_r;
  logic [63:0] diff5_r, dmag5_r;
  logic        diffneg5_r, dneg5_r;
  logic [64:0] dsub_neg;

  assign dsub_neg = 65'd0 - dsub4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind0_r    <= in_kind;
      pres0_r    <= in_partner_present;
      sep0_r     <= {in_sep_z, in_sep_y, in_sep_x};
      aux0_r     <= {in_aux_z, in_aux_y, in_aux_x};
      m1_0_r     <= in_mass_first;
      m2_0_r     <= in_mass_second;

      kind1_r    <= kind0_r;
      pres1_r    <= pres0_r;
      r1_r       <= r1_nxt;
      t1_r       <= t1_nxt;
      m1_1_r     <= m1_0_r;
      m2_1_r     <= m2_0_r;

      kind2_r    <= kind1_r;
      pres2_r    <= pres1_r;
      sq2_r      <= sq2_nxt;
      tr2_r      <= tr2_nxt;
      vec2_r     <= kind1_r ? r1_r : t1_r;
      m1_2_r     <= m1_1_r;
      m2_2_r     <= m2_1_r;
      msum2_r    <= {1'b0, m1_1_r} + {1'b0, m2_1_r};

      side3_r    <= side3_nxt;
      r2_3_r     <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      dot3_r     <= $signed(tr2_r[0]) + $signed(tr2_r[1]) + $signed(tr2_r[2]);

      side4_r    <= side3_r;
      dsub4_r    <= {1'b0, r2_3_r} - {1'b0, len_sq_r, 16'd0};
      dmag4_r    <= dabs[63:0];
      dneg4_r    <= dot3_r[65];

      side5_r    <= side4_r;
      diff5_r    <= dsub4_r[64] ? dsub_neg[63:0] : dsub4_r[63:0];
      diffneg5_r <= !dsub4_r[64] && (dsub4_r != 65'd0);
      dmag5_r    <= dmag4_r;
      dneg5_r    <= dneg4_r;
    end
  end

  // ---------------------------------------------------------------
  // Tolerance test and first division setup
  //   position: (diff << 31) / dot
  //   velocity: (|dot| << 16) / length_sq
  // ---------------------------------------------------------------
  rbc_side_t   d1_side;
  logic [63:0] d1_rem, d1_den;
  logic [62:0] d1_low;
  logic        d1_zero;

  always_comb begin
    d1_side = side5_r;
    if (side5_r.kind) begin
      d1_side.fail = (dmag5_r > {vel_tol_r, 16'd0});
      d1_side.gneg = dneg5_r;
      d1_rem       = {47'd0, dmag5_r[63:47]};
      d1_low       = {dmag5_r[46:0], 16'd0};
      d1_den       = {16'd0, len_sq_r};
      d1_zero      = (dmag5_r == 64'd0);
    end else begin
      d1_side.fail = ({diff5_r, 16'd0} > tol_ls_r);
      d1_side.gneg = diffneg5_r ^ dneg5_r;
      d1_rem       = {32'd0, diff5_r[63:32]};
      d1_low       = {diff5_r[31:0], 31'd0};
      d1_den       = dmag5_r;
      d1_zero      = (diff5_r == 64'd0);
    end
  end

  logic        q1_vld;
  logic [63:0] q1;
  rbc_side_t   q1_side;

  rbc_div_pipe u_div_factor (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v5_r),
    .in_rem   (d1_rem),
    .in_low   (d1_low),
    .in_den   (d1_den),
    .in_zero  (d1_zero),
    .in_side  (d1_side),
    .out_vld  (q1_vld),
    .out_q    (q1),
    .out_side (q1_side)
  );

  // second division: (factor << 16) / (m1 + m2)
  logic        q2_vld;
  logic [63:0] q2;
  rbc_side_t   q2_side;

  rbc_div_pipe u_div_mass (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (q1_vld),
    .in_rem   ({47'd0, q1[63:47]}),
    .in_low   ({q1[46:0], 16'd0}),
    .in_den   ({31'd0, q1_side.msum}),
    .in_zero  (q1 == 64'd0),
    .in_side  (q1_side),
    .out_vld  (q2_vld),
    .out_q    (q2),
    .out_side (q2_side)
  );

  // ---------------------------------------------------------------
  // Corrections: G * |v| * m, product split into 32-bit pieces
  //   C1: G * |v| halves   C2: join   C3: * mass pieces   C4: join
  //   index 0..2 first particle (m2), 3..5 second particle (m1)
  // ---------------------------------------------------------------
  logic             vc1_r, vc2_r, vc3_r, vc4_r;
  rbc_side_t        cs1_r, cs2_r, cs3_r, cs4_r;
  logic [2:0][63:0] alo1_r;
  logic [2:0][62:0] ahi1_r;
  logic [2:0][94:0] p2_r;
  logic [5:0][63:0] c0_3_r, c1_3_r;
  logic [5:0][62:0] c2_3_r;
  logic [5:0][126:0] pp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc1_r <= 1'b0;
      vc2_r <= 1'b0;
      vc3_r <= 1'b0;
      vc4_r <= 1'b0;
    end else if (en) begin
      vc1_r <= q2_vld;
      vc2_r <= vc1_r;
      vc3_r <= vc2_r;
      vc4_r <= vc3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs1_r <= q2_side;
      cs2_r <= cs1_r;
      cs3_r <= cs2_r;
      cs4_r <= cs3_r;
      for (int j = 0; j < 3; j++) begin
        alo1_r[j]   <= q2[31:0] * q2_side.vmag[j];
        ahi1_r[j]   <= q2[62:32] * q2_side.vmag[j];
        p2_r[j]     <= {ahi1_r[j], 32'd0} + {31'd0, alo1_r[j]};
        c0_3_r[j]   <= p2_r[j][31:0]  * cs2_r.m2;
        c1_3_r[j]   <= p2_r[j][63:32] * cs2_r.m2;
        c2_3_r[j]   <= p2_r[j][94:64] * cs2_r.m2;
        c0_3_r[j+3] <= p2_r[j][31:0]  * cs2_r.m1;
        c1_3_r[j+3] <= p2_r[j][63:32] * cs2_r.m1;
        c2_3_r[j+3] <= p2_r[j][94:64] * cs2_r.m1;
      end
      for (int k = 0; k < 6; k++) begin
        pp4_r[k] <= {63'd0, c0_3_r[k]} + {31'd0, c1_3_r[k], 32'd0} + {c2_3_r[k], 64'd0};
      end
    end
  end

  // C5: saturate, sign, mask
  rbc_word_t word_new;

  always_comb begin
    logic [63:0] mag;
    logic        neg;
    logic        apply;
    apply                 = cs4_r.pres && cs4_r.fail;
    word_new.status       = !cs4_r.pres;
    word_new.needs_repeat = apply;
    for (int k = 0; k < 6; k++) begin
      mag = (|pp4_r[k][126:95]) ? SAT_MAG : {1'b0, pp4_r[k][94:32]};
      // position: first +, second -; velocity: first -, second +
      neg = cs4_r.gneg ^ cs4_r.vneg[k % 3] ^ (k < 3 ? cs4_r.kind : !cs4_r.kind);
      if (!apply)   word_new.corr[k] = 64'd0;
      else if (neg) word_new.corr[k] = 64'd0 - mag;
      else          word_new.corr[k] = mag;
    end
  end

  // ---------------------------------------------------------------
  // Output head register + skid register
  // ---------------------------------------------------------------
  rbc_word_t head_r, skid_r;
  logic      push, pop;

  assign push = en && vc4_r;
  assign pop  = head_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        head_vld_r <= push;
      end
    end else if (push) begin
      if (head_vld_r) begin
        skid_vld_r <= 1'b1;
      end else begin
        head_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        head_r <= skid_r;
      end else if (push) begin
        head_r <= word_new;
      end
    end else if (push) begin
      if (head_vld_r) begin
        skid_r <= word_new;
      end else begin
        head_r <= word_new;
      end
    end
  end

  assign out_valid         = head_vld_r;
  assign out_status        = head_r.status;
  assign out_needs_repeat  = head_r.needs_repeat;
  assign out_corr_first_x  = head_r.corr[0];
  assign out_corr_first_y  = head_r.corr[1];
  assign out_corr_first_z  = head_r.corr[2];
  assign out_corr_second_x = head_r.corr[3];
  assign out_corr_second_y = head_r.corr[4];
  assign out_corr_second_z = head_r.corr[5];

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `RBC_ASSERT_NOW(a_missing_no_fix, out_valid && out_status, !out_needs_repeat)
  `RBC_ASSERT_NOW(a_no_fix_zero, out_valid && !out_needs_repeat, (out_corr_first_x == 64'd0) && (out_corr_first_y == 64'd0) && (out_corr_first_z == 64'd0) && (out_corr_second_x == 64'd0) && (out_corr_second_y == 64'd0) && (out_corr_second_z == 64'd0))
  `RBC_ASSERT_NOW(a_skid_needs_head, skid_vld_r, head_vld_r)
  `RBC_ASSERT_NEXT(a_skid_drains, skid_vld_r && out_ready, head_vld_r && !skid_vld_r)
  `RBC_ASSERT_NEXT(a_skid_holds, skid_vld_r && !out_ready, skid_vld_r && !in_ready)

endmodule

FILE: design/rbc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage after stage 0.
// Stage 0 registers operands and the overflow check; quotient saturates.
module rbc_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [63:0]         in_rem,
  input  logic [62:0]         in_low,
  input  logic [63:0]         in_den,
  input  logic                in_zero,
  input  rbc_pkg::rbc_side_t  in_side,
  output logic                out_vld,
  output logic [63:0]         out_q,
  output rbc_pkg::rbc_side_t  out_side
);
  import rbc_pkg::*;

  logic              vld_r  [0:QBITS];
  logic [63:0]       rem_r  [0:QBITS];
  logic [QBITS-1:0]  low_r  [0:QBITS];
  logic [QBITS-1:0]  q_r    [0:QBITS];
  logic [63:0]       den_r  [0:QBITS];
  logic              sat_r  [0:QBITS];
  logic              zero_r [0:QBITS];
  rbc_side_t         side_r [0:QBITS];

  logic [63:0]       rem_nxt  [0:QBITS];
  logic [QBITS-1:0]  low_nxt  [0:QBITS];
  logic [QBITS-1:0]  q_nxt    [0:QBITS];
  logic [63:0]       den_nxt  [0:QBITS];
  logic              sat_nxt  [0:QBITS];
  logic              zero_nxt [0:QBITS];
  rbc_side_t         side_nxt [0:QBITS];

  always_comb begin
    logic [64:0] trial;
    logic [64:0] sub;
    logic        ge;
    rem_nxt[0]  = in_rem;
    low_nxt[0]  = in_low;
    q_nxt[0]    = '0;
    den_nxt[0]  = in_den;
    sat_nxt[0]  = (in_rem >= in_den);
    zero_nxt[0] = in_zero;
    side_nxt[0] = in_side;
    for (int k = 1; k <= QBITS; k++) begin
      trial       = {rem_r[k-1], low_r[k-1][QBITS-1]};
      sub         = trial - {1'b0, den_r[k-1]};
      ge          = (trial >= {1'b0, den_r[k-1]});
      rem_nxt[k]  = ge ? sub[63:0] : trial[63:0];
      low_nxt[k]  = {low_r[k-1][QBITS-2:0], 1'b0};
      q_nxt[k]    = {q_r[k-1][QBITS-2:0], ge};
      den_nxt[k]  = den_r[k-1];
      sat_nxt[k]  = sat_r[k-1];
      zero_nxt[k] = zero_r[k-1];
      side_nxt[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QBITS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= QBITS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QBITS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        low_r[k]  <= low_nxt[k];
        q_r[k]    <= q_nxt[k];
        den_r[k]  <= den_nxt[k];
        sat_r[k]  <= sat_nxt[k];
        zero_r[k] <= zero_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[QBITS];
  assign out_side = side_r[QBITS];
  assign out_q    = zero_r[QBITS] ? 64'd0 :
                    sat_r[QBITS]  ? SAT_MAG : {1'b0, q_r[QBITS]};

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Bench for the rigid bond constraint correction unit (SHAKE / RATTLE step).
// Each input word is predicted by the scoreboard class as it is accepted;
// each result word is checked against the oldest prediction.
// Words are driven on the falling edge; handshakes and results are sampled
// on the rising edge.

typedef enum bit {KIND_POS = 1'b0, KIND_VEL = 1'b1} bond_kind_e;
typedef enum bit {STAT_OK = 1'b0, STAT_NO_PARTNER = 1'b1} bond_status_e;
typedef enum int {
  REG_BOX_X = 0, REG_BOX_Y = 1, REG_BOX_Z = 2,
  REG_LEN_SQ = 3, REG_POS_TOL = 4, REG_VEL_TOL = 5
} bond_reg_e;

typedef struct packed {
  bit             kind;
  bit             pres;
  bit [2:0][31:0] sep;
  bit [2:0][31:0] aux;
  bit [31:0]      m1;
  bit [31:0]      m2;
} bond_word_t;

typedef struct packed {
  bit             status;
  bit             repeat_flag;
  bit [5:0][63:0] corr;   // first x,y,z then second x,y,z
} corr_word_t;

class bond_scoreboard;
  localparam bit [63:0] SAT = 64'h7FFF_FFFF_FFFF_FFFF;

  bit [30:0]  box[3];
  bit [47:0]  len_sq;
  bit [31:0]  pos_tol;
  bit [47:0]  vel_tol;
  corr_word_t pending[$];
  int         errors;

  function void load_defaults();
    box[0] = 655360; box[1] = 655360; box[2] = 655360;
    len_sq = 65536; pos_tol = 4295; vel_tol = 66;
  endfunction

  function void set_reg(bond_reg_e idx, bit [63:0] v);
    case (idx)
      REG_BOX_X:   box[0] = v[30:0];
      REG_BOX_Y:   box[1] = v[30:0];
      REG_BOX_Z:   box[2] = v[30:0];
      REG_LEN_SQ:  len_sq = v[47:0];
      REG_POS_TOL: pos_tol = v[31:0];
      REG_VEL_TOL: vel_tol = v[47:0];
      default: ;
    endcase
  endfunction

  // minimum image, one shift at most, ties left alone
  function longint min_image(longint d, bit [30:0] l);
    longint ll;
    ll = longint'(l);
    if (2 * d > ll) return d - ll;
    if (2 * d < -ll) return d + ll;
    return d;
  endfunction

  function bit [63:0] magn(longint v);
    bit [63:0] u;
    u = v;
    return (v < 0) ? 64'd0 - u : u;
  endfunction

  // (m << sh) / d, saturating
  function bit [63:0] sat_quot(bit [63:0] m, int sh, bit [63:0] d);
    bit [127:0] num, q;
    num = {64'd0, m} << sh;
    if (m == 0) return 0;
    if (d == 0 || num[127:64] >= d) return SAT;
    q = num / {64'd0, d};
    return (q > {64'd0, SAT}) ? SAT : q[63:0];
  endfunction

  function bit [63:0] scaled(bit [63:0] g, bit gneg, longint t, bit [31:0] m, bit flip);
    bit [191:0] f;
    bit [63:0]  hi, res;
    f = {128'd0, g} * {128'd0, magn(t)};
    f = f * {160'd0, m};
    hi = f[127:64];
    res = (hi[63:31] != 0) ? SAT : {hi[31:0], f[63:32]};
    return (gneg ^ (t < 0) ^ flip) ? 64'd0 - res : res;
  endfunction

  // signed dot product kept as sign and magnitude, 64-bit wrapping sums
  function void dot(longint a[3], longint b[3], output bit [63:0] mag, output bit neg);
    bit [63:0] ps, ns;
    longint    p;
    ps = 0; ns = 0;
    for (int j = 0; j < 3; j++) begin
      p = a[j] * b[j];
      if (p < 0) ns += magn(p);
      else ps += p;
    end
    neg = ns > ps;
    mag = neg ? ns - ps : ps - ns;
  endfunction

  function void note_bond(bond_word_t b);
    corr_word_t e;
    longint     r[3], t[3];
    bit [63:0]  d2q, r2, diff, dmag, g0, gmag;
    bit [32:0]  msum;
    bit         diffneg, dneg, gneg;
    bit [127:0] lhs, rhs;
    e = '0;
    msum = {1'b0, b.m1} + {1'b0, b.m2};
    d2q = {len_sq, 16'd0};
    if (!b.pres) begin
      e.status = STAT_NO_PARTNER;
      pending.push_back(e);
      return;
    end
    for (int j = 0; j < 3; j++) begin
      r[j] = min_image(longint'(signed'(b.sep[j])), box[j]);
      t[j] = longint'(signed'(b.aux[j]));
    end
    if (b.kind == KIND_POS) begin
      r2 = 0;
      for (int j = 0; j < 3; j++) begin
        t[j] = min_image(t[j], box[j]);
        r2 += r[j] * r[j];
      end
      diffneg = r2 > d2q;
      diff = diffneg ? r2 - d2q : d2q - r2;
      lhs = {diff, 64'd0} >> 32;
      rhs = {64'd0, 32'd0, pos_tol} * {64'd0, d2q};
      if (lhs <= rhs) begin
        pending.push_back(e);
        return;
      end
      dot(t, r, dmag, dneg);
      g0 = sat_quot(diff, 31, dmag);
      gmag = sat_quot(g0, 16, 64'(msum));
      gneg = diffneg ^ dneg;
      for (int j = 0; j < 3; j++) begin
        e.corr[j] = scaled(gmag, gneg, t[j], b.m2, 1'b0);
        e.corr[3 + j] = scaled(gmag, gneg, t[j], b.m1, 1'b1);
      end
    end else begin
      dot(t, r, dmag, dneg);
      if (dmag <= {vel_tol, 16'd0}) begin
        pending.push_back(e);
        return;
      end
      g0 = sat_quot(dmag, 16, 64'(len_sq));
      gmag = sat_quot(g0, 16, 64'(msum));
      for (int j = 0; j < 3; j++) begin
        e.corr[j] = scaled(gmag, dneg, r[j], b.m2, 1'b1);
        e.corr[3 + j] = scaled(gmag, dneg, r[j], b.m1, 1'b0);
      end
    end
    e.repeat_flag = 1'b1;
    pending.push_back(e);
  endfunction

  function void check_word(corr_word_t got);
    corr_word_t exp_w;
    string      nm[6];
    nm = '{"corr_first_x", "corr_first_y", "corr_first_z",
           "corr_second_x", "corr_second_y", "corr_second_z"};
    if (pending.size() == 0) begin
      $error("result word with nothing pending");
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.status != exp_w.status) begin
      $error("status: expected %0d got %0d", exp_w.status, got.status);
      errors++;
    end
    if (got.repeat_flag != exp_w.repeat_flag) begin
      $error("needs_repeat: expected %0d got %0d", exp_w.repeat_flag, got.repeat_flag);
      errors++;
    end
    for (int j = 0; j < 6; j++)
      if (got.corr[j] != exp_w.corr[j]) begin
        $error("%s: expected %h got %h", nm[j], exp_w.corr[j], got.corr[j]);
        errors++;
      end
  endfunction
endclass

module tb;
  import rbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN = 160;       // pipeline is 138 deep

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic        in_partner_present = 1'b0;
  logic [31:0] in_sep_x = '0, in_sep_y = '0, in_sep_z = '0;
  logic [31:0] in_aux_x = '0, in_aux_y = '0, in_aux_z = '0;
  logic [31:0] in_mass_first = 32'd1, in_mass_second = 32'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status, out_needs_repeat;
  logic [63:0] out_corr_first_x, out_corr_first_y, out_corr_first_z;
  logic [63:0] out_corr_second_x, out_corr_second_y, out_corr_second_z;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  bond_scoreboard sb;
  bit             no_idle = 1'b0;   // phases with back-to-back traffic
  int             cycles = 0;
  int             out_hold = 0;

  rigid_bond_constraint_correction_unit dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sample both channels on the rising edge (pre-edge values)
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_bond('{in_kind, in_partner_present,
                       {in_sep_z, in_sep_y, in_sep_x},
                       {in_aux_z, in_aux_y, in_aux_x},
                       in_mass_first, in_mass_second});
      if (out_valid && out_ready)
        sb.check_word('{out_status, out_needs_repeat,
                        {out_corr_second_z, out_corr_second_y, out_corr_second_x,
                         out_corr_first_z, out_corr_first_y, out_corr_first_x}});
    end
  end

  // receiver stalls: mostly ready, short stalls, now and then a long one
  always @(negedge clk) begin
    int pick;
    pick = $urandom_range(0, 15);
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (no_idle || pick < 9) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      out_hold <= (pick < 14) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 15);
    if (no_idle || p < 9) return 0;
    if (p < 15) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_bond(bond_word_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= b.kind;
    in_partner_present <= b.pres;
    {in_sep_z, in_sep_y, in_sep_x} <= b.sep;
    {in_aux_z, in_aux_y, in_aux_x} <= b.aux;
    in_mass_first <= b.m1;
    in_mass_second <= b.m2;
    do @(posedge clk); while (!in_ready);
  endtask

  // setup phase, access phase, then release
  task automatic write_reg(bond_reg_e idx, bit [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx * 8);
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_all(bit [30:0] bx, bit [30:0] by, bit [30:0] bz,
                           bit [47:0] lsq, bit [31:0] pt, bit [47:0] vt);
    write_reg(REG_BOX_X, 64'(bx));
    write_reg(REG_BOX_Y, 64'(by));
    write_reg(REG_BOX_Z, 64'(bz));
    write_reg(REG_LEN_SQ, 64'(lsq));
    write_reg(REG_POS_TOL, 64'(pt));
    write_reg(REG_VEL_TOL, 64'(vt));
  endtask

  function automatic bit [31:0] rand_coord();
    int p;
    p = $urandom_range(0, 3);
    if (p == 0) return $urandom;
    return 32'($urandom_range(0, 32 * 65536)) - 32'(16 * 65536);
  endfunction

  function automatic bit [31:0] rand_mass();
    bit [31:0] m;
    if ($urandom_range(0, 1)) m = $urandom_range(1 << 12, 1 << 20);
    else m = $urandom;
    return (m == 0) ? 32'd1 : m;
  endfunction

  function automatic bond_word_t rand_bond();
    bond_word_t b;
    b.kind = $urandom_range(0, 1);
    b.pres = ($urandom_range(0, 15) != 0);
    for (int j = 0; j < 3; j++) begin
      b.sep[j] = rand_coord();
      b.aux[j] = rand_coord();
    end
    b.m1 = rand_mass();
    b.m2 = rand_mass();
    return b;
  endfunction

  function automatic bond_word_t mk(bit k, bit p, bit [31:0] sx, bit [31:0] sy,
                                   bit [31:0] sz, bit [31:0] ax, bit [31:0] ay,
                                   bit [31:0] az, bit [31:0] m1, bit [31:0] m2);
    return '{k, p, {sz, sy, sx}, {az, ay, ax}, m1, m2};
  endfunction

  localparam bit [31:0] ONE = 32'h0001_0000;
  localparam bit [31:0] MAXP = 32'h7FFF_FFFF;
  localparam bit [31:0] MINN = 32'h8000_0000;
  localparam bit [31:0] MMAX = 32'hFFFF_FFFF;

  initial begin
    sb = new();
    sb.load_defaults();
    sb.errors = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words under reset defaults (box 10.0, bond length 1.0)
    send_bond(mk(KIND_POS, 1'b0, ONE, ONE, ONE, ONE, 0, 0, ONE, ONE));   // no partner
    send_bond(mk(KIND_VEL, 1'b0, MINN, MAXP, 0, MMAX, 0, 0, 1, MMAX));  // no partner
    send_bond(mk(KIND_POS, 1'b1, ONE, 0, 0, ONE, 0, 0, ONE, ONE));      // exact length
    send_bond(mk(KIND_POS, 1'b1, 2 * ONE, 0, 0, 0, ONE, 0, ONE, ONE));  // t.r zero
    send_bond(mk(KIND_POS, 1'b1, 0, 0, 0, ONE, ONE, ONE, ONE, 3 * ONE)); // r2 zero
    send_bond(mk(KIND_POS, 1'b1, 5 * ONE, -5 * ONE, 6 * ONE,           // fold ties
                 5 * ONE, -6 * ONE, ONE, ONE, ONE));
    send_bond(mk(KIND_POS, 1'b1, MAXP, MINN, MAXP, MINN, MAXP, MINN, 1, 1));
    send_bond(mk(KIND_POS, 1'b1, MINN, MINN, MINN, MAXP, MAXP, MAXP, MMAX, MMAX));
    send_bond(mk(KIND_POS, 1'b1, ONE + 3, 7, 0, ONE, 3, 0, 1, MMAX));
    send_bond(mk(KIND_VEL, 1'b1, ONE, 0, 0, 0, ONE, 0, ONE, ONE));      // dot zero
    send_bond(mk(KIND_VEL, 1'b1, ONE, 0, 0, 66, 0, 0, ONE, ONE));       // dot at tol
    send_bond(mk(KIND_VEL, 1'b1, ONE, 0, 0, 67, 0, 0, ONE, ONE));       // just above
    send_bond(mk(KIND_VEL, 1'b1, MAXP, MINN, MAXP, MAXP, MINN, MAXP, 1, 1));
    send_bond(mk(KIND_VEL, 1'b1, MINN, MINN, MINN, MMAX, MMAX, MMAX, MMAX, MMAX));
    send_bond(mk(KIND_VEL, 1'b1, -ONE, ONE, -ONE, 3 * ONE, -ONE, 0, 1, MMAX));
    for (int i = 0; i < 150; i++) send_bond(rand_bond());
    drain();

    // config phases: smallest values, largest values, one fixed mix, then random settings
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_all(1, 1, 1, 1, 0, 0);
        1: write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                     48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        2: write_all(20 * ONE, 3 * ONE, 31'(ONE) + 1, 4 * ONE, 32'h8000_0000, 0);
        default:
          write_all($urandom_range(1, 31'h7FFF_FFFF), $urandom_range(1, 64 * ONE),
                    $urandom_range(1, 64 * ONE),
                    {16'($urandom_range(0, 3)), 32'($urandom)} | 48'd1,
                    $urandom, {16'($urandom_range(0, 1)), 32'($urandom_range(0, ONE))});
      endcase
      no_idle = (ph == 4 || ph == 7);
      for (int i = 0; i < 210; i++) send_bond(rand_bond());
      drain();
    end

    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
